// File: rtl/core/qfe_pkg.sv
// Package for the quadratic form engine: sizes, transfer payload types and
// the sequencer state type. Depends on nothing; imported by the top level.
package qfe_pkg;

    // Matrix size and element format
    localparam int MAX_DIMENSION = 16;
    localparam int VALUE_WIDTH   = 16;

    // Derived widths
    localparam int DIM_W   = 5;
    localparam int IDX_W   = $clog2(MAX_DIMENSION);
    localparam int CNT_W   = $clog2(MAX_DIMENSION + 2);
    localparam int ADDR_W  = $clog2(MAX_DIMENSION * MAX_DIMENSION);
    localparam int PROD1_W = 2 * VALUE_WIDTH;
    localparam int PROD2_W = 3 * VALUE_WIDTH;
    localparam int TERM_W  = PROD2_W + 1;
    localparam int SUM_W   = 64;
    localparam int ACC_W   = SUM_W + 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIMENSION);

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_VECTOR = 1'b1;

    // Input transfer payload
    typedef struct packed {
        logic                          command;
        logic [3:0]                    row;
        logic [3:0]                    column;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last;
    } qfe_item_t;

    // Output transfer payload
    typedef struct packed {
        logic signed [SUM_W-1:0] form_value;
        logic                    size_error;
    } qfe_result_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } qfe_state_t;

endpackage

// File: rtl/core/quadratic_form_engine.sv
// Quadratic form engine top level: matrix and vector memories, term sequencer,
// two-stage multiplier and saturating accumulator. Depends on qfe_pkg.
//
// Usage: the item channel (item, item_valid, item_stall) carries two kinds of
// transfer. A write (command 0) stores one entry of the symmetric matrix A at
// (row, column); only the diagonal and lower triangle are used. A vector
// transfer (command 1) supplies the next element x_k of the query vector; the
// element flagged last closes the query and produces one transfer on the
// result channel (result, result_valid, result_stall) holding x'Ax in signed
// Q40.24, saturated, and a size_error flag when the element count differs
// from the dimension register (cfg_we / cfg_wdata, reset value 16) or that
// register is 0 or above 16. A write does not raise item_stall. Element k
// issues k+1 reads of the matrix memory, one per cycle, through a single
// multiply-accumulate path (memory read, two multiplier stages, accumulate),
// and item_stall stays high until that path has drained; an element past
// the dimension issues no reads. A closing element then has its sum moved
// into the output register.
// The block takes one item at a time; item_stall is high while an element is
// being processed. The output register holds a result while result_stall is
// high; the next items are still taken until another result is ready.
// Reset clears the query state and returns the dimension to 16; the matrix
// contents are undefined until written.
module quadratic_form_engine
    import qfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  qfe_item_t         item,
    input  logic              item_valid,
    output logic              item_stall,
    output qfe_result_t       result,
    output logic              result_valid,
    input  logic              result_stall,
    input  logic              cfg_we,
    input  logic [DIM_W-1:0]  cfg_wdata
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Memories
    logic signed [VALUE_WIDTH-1:0] matrix_mem [MAX_DIMENSION*MAX_DIMENSION];
    logic signed [VALUE_WIDTH-1:0] vector_mem [MAX_DIMENSION];

    // Control registers
    qfe_state_t        state_reg, state_next;
    logic [DIM_W-1:0]  dimension_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  step_reg;
    logic              last_reg;
    logic              err_reg;
    logic              rd_v_reg, m1_v_reg, m2_v_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic              ovf_reg;
    logic              result_valid_reg;

    // Payload registers
    logic signed [VALUE_WIDTH-1:0] x_reg;
    logic signed [VALUE_WIDTH-1:0] mat_q_reg;
    logic signed [VALUE_WIDTH-1:0] vec_q_reg;
    logic                          rd_diag_reg;
    logic signed [PROD1_W-1:0]     prod1_reg;
    logic signed [VALUE_WIDTH-1:0] coef_reg;
    logic                          dbl_reg;
    logic signed [TERM_W-1:0]      term_reg;
    qfe_result_t                   result_reg;

    // Combinational signals
    logic                          accept;
    logic                          issue;
    logic                          load_out;
    logic                          out_free;
    logic                          pipe_empty;
    logic                          do_terms;
    logic [CNT_W-1:0]              edim;
    logic [CNT_W-1:0]              count_inc;
    logic                          size_err;
    logic                          mat_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [IDX_W-1:0]              jidx;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [VALUE_WIDTH-1:0] mul_b;
    logic signed [PROD1_W-1:0]     prod1;
    logic signed [PROD2_W-1:0]     prod2;
    logic signed [TERM_W-1:0]      term;
    logic signed [ACC_W-1:0]       acc;
    logic                          acc_ovf;
    logic signed [SUM_W-1:0]       sum_sat;

    // Handshake and query bookkeeping
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign pipe_empty = !rd_v_reg && !m1_v_reg && !m2_v_reg;

    assign edim = (dimension_reg > DIM_W'(MAX_DIMENSION)) ? CNT_W'(MAX_DIMENSION)
                                                         : CNT_W'(dimension_reg);
    assign do_terms  = (item.command == CMD_VECTOR) && (count_reg < edim);
    assign count_inc = (count_reg < CNT_W'(MAX_DIMENSION + 1)) ? count_reg + 1'b1
                                                               : count_reg;
    assign size_err  = (dimension_reg == '0) ||
                       (dimension_reg > DIM_W'(MAX_DIMENSION)) ||
                       (DIM_W'(count_inc) != dimension_reg);

    always_comb
    begin
        count_next = count_reg;
        if (accept && item.command == CMD_VECTOR)
        begin
            count_next = item.last ? '0 : count_inc;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.command == CMD_VECTOR)
                begin
                    if (do_terms)
                        state_next = ST_RUN;
                    else if (item.last)
                        state_next = ST_EMIT;
                end
            end
            ST_RUN:
            begin
                if (step_reg == k_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        item_stall = 1'b1;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  item_stall = 1'b0;
            ST_RUN:   issue = 1'b1;
            ST_DRAIN: ;
            ST_EMIT:  load_out = out_free;
            default:  ;
        endcase
    end

    // Memory addresses: step 0 is the diagonal, step s is column s-1
    assign mat_we  = accept && (item.command == CMD_WRITE) &&
                     (int'(item.row) < MAX_DIMENSION) &&
                     (int'(item.column) < MAX_DIMENSION);
    assign wr_addr = ADDR_W'(ADDR_W'(item.row) * ADDR_W'(MAX_DIMENSION) +
                             ADDR_W'(item.column));
    assign jidx    = (step_reg == '0) ? k_reg : step_reg - 1'b1;
    assign rd_addr = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(MAX_DIMENSION) + ADDR_W'(jidx));

    // Matrix memory
    always_ff @(posedge clk)
    begin
        if (mat_we)
            matrix_mem[wr_addr] <= item.value;
        if (issue)
            mat_q_reg <= matrix_mem[rd_addr];
    end

    // Vector memory; element k is written at accept, reads touch j <= k
    always_ff @(posedge clk)
    begin
        if (accept && do_terms)
            vector_mem[count_reg[IDX_W-1:0]] <= item.value;
        if (issue)
            vec_q_reg <= vector_mem[jidx];
    end

    // Multiplier stages and doubled cross term
    assign mul_b = rd_diag_reg ? x_reg : vec_q_reg;
    assign prod1 = PROD1_W'(x_reg) * PROD1_W'(mul_b);
    assign prod2 = PROD2_W'(prod1_reg) * PROD2_W'(coef_reg);
    assign term  = dbl_reg ? {prod2, 1'b0} : {prod2[PROD2_W-1], prod2};

    always_ff @(posedge clk)
    begin
        if (accept && do_terms)
            x_reg <= item.value;
        if (issue)
            rd_diag_reg <= (step_reg == '0);
        if (rd_v_reg)
        begin
            prod1_reg <= prod1;
            coef_reg  <= mat_q_reg;
            dbl_reg   <= !rd_diag_reg;
        end
        if (m1_v_reg)
            term_reg <= term;
        if (load_out)
            result_reg <= '{form_value: sum_reg, size_error: err_reg};
    end

    // Saturating accumulate
    assign acc     = {sum_reg[SUM_W-1], sum_reg} +
                     {{(ACC_W-TERM_W){term_reg[TERM_W-1]}}, term_reg};
    assign acc_ovf = acc[ACC_W-1] != acc[ACC_W-2];
    assign sum_sat = acc_ovf ? (acc[ACC_W-1] ? SUM_MIN : SUM_MAX) : acc[SUM_W-1:0];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dimension_reg    <= DIM_RESET;
            count_reg        <= '0;
            k_reg            <= '0;
            step_reg         <= '0;
            last_reg         <= 1'b0;
            err_reg          <= 1'b0;
            rd_v_reg         <= 1'b0;
            m1_v_reg         <= 1'b0;
            m2_v_reg         <= 1'b0;
            sum_reg          <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                dimension_reg <= cfg_wdata;
            if (accept && item.command == CMD_VECTOR)
            begin
                k_reg    <= count_reg[IDX_W-1:0];
                step_reg <= '0;
                last_reg <= item.last;
                err_reg  <= size_err;
            end
            else if (issue)
            begin
                step_reg <= step_reg + 1'b1;
            end
            rd_v_reg <= issue;
            m1_v_reg <= rd_v_reg;
            m2_v_reg <= m1_v_reg;
            // sum pins once it has clamped
            if (load_out)
            begin
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (m2_v_reg && !ovf_reg)
            begin
                sum_reg <= sum_sat;
                ovf_reg <= acc_ovf;
            end
            if (load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Checks
    a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> pipe_empty)
        else $error("item transfer while multiply pipeline busy");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= k_reg))
        else $error("term step beyond current element");

    a_ovf_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (sum_reg == SUM_MAX || sum_reg == SUM_MIN))
        else $error("overflow flagged but sum not at a limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIMENSION + 1))
        else $error("element count beyond saturation limit");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall && state_reg == ST_EMIT) |=>
            (state_reg == ST_EMIT || !$stable(result_valid_reg) || $stable(result_reg)))
        else $error("held result overwritten");

endmodule

// File: tb/qfe_checker.sv
// Checker for the quadratic form engine: watches the item, result and config
// channels, predicts each x'Ax result and compares it. Depends on qfe_pkg.
module qfe_checker
    import qfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  qfe_item_t         item,
    input  logic              item_valid,
    input  logic              item_stall,
    input  qfe_result_t       result,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic              cfg_we,
    input  logic [DIM_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending
);

    localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    // Shadow copy of the block state
    logic signed [VALUE_WIDTH-1:0] coef_mem [MAX_DIMENSION][MAX_DIMENSION];
    logic signed [VALUE_WIDTH-1:0] elem_mem [MAX_DIMENSION];
    logic [DIM_W-1:0]              dim_reg;
    int                            elem_count;
    longint                        form_sum;
    bit                            form_pinned;
    int                            errors;

    qfe_result_t expected_forms [$];

    // Saturating accumulate; once pinned the sum holds until the query ends
    task automatic add_term(input longint t);
        logic [64:0] s;
        if (!form_pinned)
        begin
            s = {form_sum[63], form_sum} + {t[63], t};
            if (s[64] != s[63])
            begin
                form_pinned = 1'b1;
                form_sum    = s[64] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                form_sum = s[63:0];
            end
        end
    endtask

    // One vector element: diagonal term, then doubled cross terms in order
    task automatic predict_element(input qfe_item_t it);
        int          edim;
        int          k;
        longint      x;
        qfe_result_t res;
        edim = (dim_reg > MAX_DIMENSION) ? MAX_DIMENSION : int'(dim_reg);
        k    = elem_count;
        x    = longint'(it.value);
        if (k < edim)
        begin
            elem_mem[k] = it.value;
            add_term(x * x * longint'(coef_mem[k][k]));
            for (int j = 0; j < k; j++)
            begin
                add_term(2 * x * longint'(elem_mem[j]) * longint'(coef_mem[k][j]));
            end
        end
        if (elem_count < MAX_DIMENSION + 1)
            elem_count++;
        if (it.last)
        begin
            res.form_value = form_sum;
            res.size_error = (dim_reg == 0) || (dim_reg > MAX_DIMENSION) ||
                             (elem_count != int'(dim_reg));
            expected_forms.push_back(res);
            elem_count  = 0;
            form_sum    = 0;
            form_pinned = 1'b0;
        end
    endtask

    // Monitor all channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        qfe_result_t want;
        if (!rst_n)
        begin
            dim_reg     = DIM_RESET;
            elem_count  = 0;
            form_sum    = 0;
            form_pinned = 1'b0;
            errors      = 0;
            expected_forms.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
                dim_reg = cfg_wdata;

            // Item transfer: matrix write or vector element
            if (item_valid && !item_stall)
            begin
                if (item.command == CMD_WRITE)
                    coef_mem[item.row][item.column] = item.value;
                else
                    predict_element(item);
            end

            // Result transfer: compare with the oldest expected form
            if (result_valid && !result_stall)
            begin
                if (expected_forms.size() == 0)
                begin
                    $error("result with no expected form: form_value=%0d size_error=%0b",
                           result.form_value, result.size_error);
                    errors++;
                end
                else
                begin
                    want = expected_forms.pop_front();
                    if (result.form_value !== want.form_value)
                    begin
                        $error("form_value mismatch: expected %0d, actual %0d",
                               want.form_value, result.form_value);
                        errors++;
                    end
                    if (result.size_error !== want.size_error)
                    begin
                        $error("size_error mismatch: expected %0b, actual %0b",
                               want.size_error, result.size_error);
                        errors++;
                    end
                end
            end

            fail_count <= errors;
            pending    <= expected_forms.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the quadratic form engine testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on qfe_pkg and qfe_checker.
module testbench
    import qfe_pkg::*;
();

    localparam int STIM_ITEMS  = 2000;
    localparam int CALM_ITEMS  = 1800;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_WAIT   = 25;
    localparam int CYCLE_LIMIT = 400000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    qfe_item_t        item_bus     = '0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    qfe_result_t      result_bus;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic             cfg_we       = 1'b0;
    logic [DIM_W-1:0] cfg_wdata    = '0;

    int               fail_count;
    int               pending;

    bit               calm       = 1'b0;
    bit               tx_gappy   = 1'b1;
    int               stim_count = 0;
    int               cycle_count = 0;
    int               rx_cycles  = 0;
    bit               rx_gappy   = 1'b1;
    logic [DIM_W-1:0] cur_dim    = DIM_RESET;
    bit               written [MAX_DIMENSION][MAX_DIMENSION];

    quadratic_form_engine uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_bus),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    qfe_checker form_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_bus),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Values biased toward the extremes of Q8.8
    function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'd17;
            5: return DIM_W'($urandom_range(0, 31));
            default: return DIM_W'($urandom_range(1, 16));
        endcase
    endfunction

    // Offer one item until transferred, then maybe leave a gap
    task automatic transfer_item(input qfe_item_t it);
        item_bus   <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (it.command == CMD_WRITE)
            written[it.row][it.column] = 1'b1;
        if (it.command == CMD_VECTOR || it.row >= it.column)
            stim_count++;
        if (stim_count % 64 == 0)
            tx_gappy = ($urandom_range(0, 2) != 0);
        if (!calm && tx_gappy && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_write(input logic [3:0] r, input logic [3:0] c,
                              input logic signed [VALUE_WIDTH-1:0] v, input logic lst);
        qfe_item_t it;
        it.command = CMD_WRITE;
        it.row     = r;
        it.column  = c;
        it.value   = v;
        it.last    = lst;
        transfer_item(it);
    endtask

    task automatic send_element(input logic signed [VALUE_WIDTH-1:0] v, input logic lst);
        qfe_item_t it;
        it.command = CMD_VECTOR;
        it.row     = 4'($urandom);
        it.column  = 4'($urandom);
        it.value   = v;
        it.last    = lst;
        transfer_item(it);
    endtask

    // Register write once the block has drained
    task automatic set_dimension(input logic [DIM_W-1:0] d);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_dim = d;
    endtask

    // Query of len elements; lower-triangle rows it reads get written first
    task automatic run_query(input int len);
        int edim;
        int need;
        edim = (cur_dim > MAX_DIMENSION) ? MAX_DIMENSION : int'(cur_dim);
        need = (len < edim) ? len : edim;
        for (int r = 0; r < need; r++)
        begin
            for (int c = 0; c <= r; c++)
            begin
                if (!written[r][c])
                    send_write(4'(r), 4'(c), rand_value(), 1'($urandom));
            end
        end
        for (int i = 0; i < len; i++)
            send_element(rand_value(), i == len - 1);
    endtask

    // Receiver: stall bursts, one long hold-off, none in the last part
    initial
    begin
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles % 128 == 0)
                rx_gappy = ($urandom_range(0, 2) != 0);
            if (!calm && rx_cycles == 3000)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!calm && rx_gappy && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int pick;
        int len;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-element queries at the value extremes
        set_dimension(5'd1);
        send_write(4'd0, 4'd0, 16'sh7fff, 1'b0);
        send_element(16'sh8000, 1'b1);
        send_write(4'd0, 4'd0, 16'sh8000, 1'b0);
        send_element(16'sh7fff, 1'b1);

        // Directed: 3x3, upper-triangle write and last on a write
        set_dimension(5'd3);
        send_write(4'd1, 4'd0, 16'sh8000, 1'b0);
        send_write(4'd1, 4'd1, 16'sh7fff, 1'b0);
        send_write(4'd2, 4'd0, 16'sh7fff, 1'b0);
        send_write(4'd2, 4'd1, 16'sh8000, 1'b0);
        send_write(4'd2, 4'd2, -16'sd1, 1'b1);
        send_write(4'd0, 4'd2, 16'sh1234, 1'b1);
        send_element(16'sh8000, 1'b0);
        send_element(16'sh7fff, 1'b0);
        send_element(16'sh8000, 1'b1);

        // Directed: too few, then too many elements
        send_element(16'sd256, 1'b0);
        send_element(-16'sd256, 1'b1);
        for (int i = 0; i < 5; i++)
            send_element(16'sh7fff - 16'(i), i == 4);

        // Directed: zero dimension
        set_dimension(5'd0);
        send_element(16'sd100, 1'b1);

        // Random: mostly well-formed queries, some broken ones and write noise
        stim_count = 0;
        while (stim_count < STIM_ITEMS)
        begin
            if (stim_count >= CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                set_dimension(rand_dim());
            end
            else if (pick < 70)
            begin
                if (cur_dim >= 1 && cur_dim <= MAX_DIMENSION)
                    len = int'(cur_dim);
                else
                    len = $urandom_range(1, 18);
                run_query(len);
            end
            else if (pick < 82)
            begin
                run_query($urandom_range(1, 20));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_write(4'($urandom), 4'($urandom), rand_value(), 1'($urandom));
            end
        end

        // Drain and give the verdict
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
